/* src/pcr_pkg.sv */
// shared constants and controller-to-datapath command type for the philox generator
package pcr_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 10;

  localparam logic [31:0] MUL_A  = 32'hD2511F53;
  localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
  localparam logic [31:0] WEYL_A = 32'h9E3779B9;
  localparam logic [31:0] WEYL_B = 32'hBB67AE85;

  typedef struct packed {
    logic load;     // take counter and seed into the working block, step the counter
    logic round;    // apply one round and bump the key
    logic publish;  // copy the finished block into the output registers
  } pcr_cmd_t;

endpackage

/* src/philox_counter_rng.sv */
// philox 4x32 counter-based generator: top level joining controller and datapath
// a draw accepted in idle is loaded, run through ROUND_COUNT rounds in the shared round unit, then
// published once the output slot is free; out_valid rises with the publish
// a new draw is taken only after the last one is published; a draw-low transaction is taken in idle
// reset: synchronous, clears seed, counter, controller state and the output valid flag
module philox_counter_rng
  import pcr_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_write,
  input  logic [63:0] seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word0,
  output logic [31:0] word1,
  output logic [31:0] word2,
  output logic [31:0] word3,
  output logic [23:0] uniform_fraction
);

  pcr_cmd_t cmd;

  pcr_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .draw     (draw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  pcr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .seed_write      (seed_write),
    .seed            (seed),
    .cmd             (cmd),
    .word0           (word0),
    .word1           (word1),
    .word2           (word2),
    .word3           (word3),
    .uniform_fraction(uniform_fraction)
  );

endmodule

/* src/pcr_ctrl.sv */
// controller: sequences load, rounds and publish, owns both handshakes
module pcr_ctrl
  import pcr_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     draw,
  output logic     out_valid,
  input  logic     out_stall,
  output pcr_cmd_t cmd
);

  localparam int unsigned RCW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RCW-1:0] LAST_ROUND = RCW'(ROUND_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t         state;
  logic [RCW-1:0] round_cnt;
  logic           in_take;
  logic           out_free;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // output slot is free if empty or being emptied this cycle
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.load    = in_take && draw;
    cmd.round   = (state == ST_RUN);
    cmd.publish = (state == ST_HOLD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !cmd.publish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          round_cnt <= '0;
          if (in_take && draw) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (round_cnt == LAST_ROUND) begin
            state <= ST_HOLD;
          end else begin
            round_cnt <= round_cnt + 1'b1;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/pcr_datapath.sv */
// datapath: seed and counter registers, round logic, key schedule, output registers
module pcr_datapath
  import pcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_write,
  input  logic [63:0] seed,
  input  pcr_cmd_t    cmd,
  output logic [31:0] word0,
  output logic [31:0] word1,
  output logic [31:0] word2,
  output logic [31:0] word3,
  output logic [23:0] uniform_fraction
);

  logic [63:0] key;
  logic [63:0] draw_counter;
  logic [31:0] blk0, blk1, blk2, blk3;
  logic [31:0] k0, k1;
  logic [63:0] prod_a, prod_b;

  assign prod_a = {32'd0, MUL_A} * {32'd0, blk0};
  assign prod_b = {32'd0, MUL_B} * {32'd0, blk2};

  always_ff @(posedge clk) begin
    if (rst) begin
      key          <= '0;
      draw_counter <= '0;
    end else if (seed_write) begin
      key          <= seed;
      draw_counter <= '0;
    end else if (cmd.load) begin
      draw_counter <= draw_counter + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      blk0 <= draw_counter[31:0];
      blk1 <= draw_counter[63:32];
      blk2 <= '0;
      blk3 <= '0;
      k0   <= key[31:0];
      k1   <= key[63:32];
    end else if (cmd.round) begin
      blk0 <= prod_b[63:32] ^ blk1 ^ k0;
      blk1 <= prod_b[31:0];
      blk2 <= prod_a[63:32] ^ blk3 ^ k1;
      blk3 <= prod_a[31:0];
      // bump after the last round is harmless, the key is reloaded per draw
      k0   <= k0 + WEYL_A;
      k1   <= k1 + WEYL_B;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      word0            <= blk0;
      word1            <= blk1;
      word2            <= blk2;
      word3            <= blk3;
      uniform_fraction <= blk0[31:8];
    end
  end

endmodule

/* src/pcr_checker.sv */
// port-level assertions for the philox generator and their bind
module pcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        draw,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] word0,
  input logic [23:0] uniform_fraction
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(word0) && $stable(uniform_fraction))
    else $error("result changed while stalled");

  // a draw transaction keeps the input side busy while rounds run
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && draw |=> in_stall && !$rose(out_valid))
    else $error("input taken or result shown straight after a draw");

  // results only appear at the end of a busy period
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a draw in flight");

  a_fraction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> uniform_fraction == word0[31:8])
    else $error("fraction does not match word0");

endmodule

bind philox_counter_rng pcr_checker u_pcr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .draw            (draw),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .word0           (word0),
  .uniform_fraction(uniform_fraction)
);

/* test/tb.sv */
// self-checking testbench for the philox counter generator: queued draws, seed phases, stalls
module tb;
  import pcr_pkg::*;

  localparam int unsigned ROUNDS      = ROUND_COUNT_DEF;
  localparam int unsigned LATENCY     = ROUNDS + 2;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 200;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic DRAW_NONE = 1'b0;
  localparam logic DRAW_REQ  = 1'b1;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [23:0] frac;
  } philox_block_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        seed_write = 1'b0;
  logic [63:0] seed       = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        draw       = DRAW_NONE;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic [23:0] uniform_fraction;

  philox_counter_rng #(
    .ROUND_COUNT(ROUNDS)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .seed_write       (seed_write),
    .seed             (seed),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .draw             (draw),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .word0            (word0),
    .word1            (word1),
    .word2            (word2),
    .word3            (word3),
    .uniform_fraction (uniform_fraction)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic          pending_draws[$];
  philox_block_t expected_blocks[$];

  logic [63:0] key_model;
  logic [63:0] ctr_model;
  bit          in_fire;
  bit          all_quiet;
  bit          idle_en;
  int          send_gap;
  int          stall_left;
  int          holds_requested;
  int          holds_served;
  int          quiet_cycles;
  int          mismatches;
  int          results_checked;
  int          draws_accepted;
  int          empty_transactions;
  int          seeds_written;

  function automatic philox_block_t philox_mix(input logic [63:0] ctr, input logic [63:0] key);
    logic [31:0]   w0, w1, w2, w3, k0, k1, n0, n2;
    logic [63:0]   pa, pb;
    philox_block_t res;
    int            r;
    w0 = ctr[31:0];
    w1 = ctr[63:32];
    w2 = '0;
    w3 = '0;
    k0 = key[31:0];
    k1 = key[63:32];
    for (r = 0; r < ROUNDS; r++) begin
      pa = {32'd0, MUL_A} * {32'd0, w0};
      pb = {32'd0, MUL_B} * {32'd0, w2};
      n0 = pb[63:32] ^ w1 ^ k0;
      n2 = pa[63:32] ^ w3 ^ k1;
      w1 = pb[31:0];
      w3 = pa[31:0];
      w0 = n0;
      w2 = n2;
      // no key bump after the last round
      if (r != ROUNDS - 1) begin
        k0 = k0 + WEYL_A;
        k1 = k1 + WEYL_B;
      end
    end
    res.word0 = w0;
    res.word1 = w1;
    res.word2 = w2;
    res.word3 = w3;
    res.frac  = w0[31:8];
    return res;
  endfunction

  // monitor: seed and draw transactions feed the predictor, results are checked in order
  always @(posedge clk) begin
    philox_block_t got, want;
    if (rst) begin
      in_fire   = 1'b0;
      key_model = '0;
      ctr_model = '0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (seed_write) begin
        key_model = seed;
        ctr_model = '0;
        seeds_written++;
      end
      if (in_fire) begin
        if (draw == DRAW_REQ) begin
          expected_blocks.push_back(philox_mix(ctr_model, key_model));
          ctr_model = ctr_model + 64'd1;
          draws_accepted++;
        end else begin
          empty_transactions++;
        end
      end
      if (out_valid && !out_stall) begin
        got = {word0, word1, word2, word3, uniform_fraction};
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: w0=%h w1=%h w2=%h w3=%h frac=%h",
                     word0, word1, word2, word3, uniform_fraction);
        end else begin
          want = expected_blocks.pop_front();
          results_checked++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch on result %0d:", results_checked);
              $display("  expected w0=%h w1=%h w2=%h w3=%h frac=%h",
                       want.word0, want.word1, want.word2, want.word3, want.frac);
              $display("  actual   w0=%h w1=%h w2=%h w3=%h frac=%h",
                       got.word0, got.word1, got.word2, got.word3, got.frac);
            end
          end
        end
      end
    end
    all_quiet = (pending_draws.size() == 0) && !in_valid && (expected_blocks.size() == 0);
  end

  // draw driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (in_valid && !in_fire) begin
      // stalled transaction stays on the port
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (pending_draws.size() > 0) begin
      draw     <= pending_draws.pop_front();
      in_valid <= 1'b1;
      if (idle_en && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      stall_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || seed_write) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic wait_drained;
    // let the monitor see freshly queued items before trusting all_quiet
    @(posedge clk);
    do @(negedge clk); while (!all_quiet);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] key);
    @(negedge clk);
    seed       <= key;
    seed_write <= 1'b1;
    @(negedge clk);
    seed_write <= 1'b0;
  endtask

  task automatic queue_pattern(input logic [15:0] pattern, input int len);
    int i;
    @(posedge clk);
    for (i = 0; i < len; i++)
      pending_draws.push_back(pattern[i]);
  endtask

  task automatic queue_random(input int n_draws);
    int n;
    n = 0;
    @(posedge clk);
    while (n < n_draws) begin
      if ($urandom_range(0, 4) == 0) begin
        pending_draws.push_back(DRAW_NONE);
      end else begin
        pending_draws.push_back(DRAW_REQ);
        n++;
      end
    end
  endtask

  initial begin
    int ph;
    idle_en = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset key first, then extremes of the key, with draw-low transactions mixed in
    queue_pattern(16'b0100_1101, 8);
    wait_drained;
    write_seed('1);
    queue_pattern(16'b0011_1011, 6);
    wait_drained;
    write_seed('0);
    queue_pattern(16'b0000_1111, 4);
    wait_drained;
    write_seed(64'h0000_0000_FFFF_FFFF);
    queue_pattern(16'b0000_1011, 4);
    wait_drained;
    write_seed(64'hFFFF_FFFF_0000_0000);
    queue_pattern(16'b0000_1101, 4);
    wait_drained;

    for (ph = 0; ph < 6; ph++) begin
      write_seed({$urandom, $urandom});
      @(posedge clk);
      if (ph == 5)
        idle_en = 1'b0;
      // long receiver hold while the sender keeps offering
      if (ph == 1)
        holds_requested++;
      queue_random(40);
      // sender pause mid-phase, same key, counter carries on
      if (ph == 2)
        wait_drained;
      queue_random(40);
      wait_drained;
    end

    if (expected_blocks.size() != 0) begin
      mismatches += expected_blocks.size();
      $display("%0d expected results never arrived", expected_blocks.size());
    end
    $display("checked %0d results from %0d draws over %0d seed writes, %0d draw-low transactions",
             results_checked, draws_accepted, seeds_written, empty_transactions);
    $display("%0d mismatches in total", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
